@@ rtl/format_spec_parser_unit_assert.svh @@
// Assertion macros for the format specifier parser.
`ifndef FORMAT_SPEC_PARSER_UNIT_ASSERT_SVH
`define FORMAT_SPEC_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define FSP_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define FSP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FSP_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define FSP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

@@ rtl/fsp_pkg.sv @@
package fsp_pkg;

	localparam int unsigned NUM_W = 16;
	localparam logic [19:0] LIMIT_VALUE = 20'd65535;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

	// Bit positions in the flag vector.
	localparam int unsigned FBIT_LEFT = 0;
	localparam int unsigned FBIT_SIGN = 1;
	localparam int unsigned FBIT_ALT  = 2;
	localparam int unsigned FBIT_PAD  = 3;

	typedef enum logic [2:0] {
		PH_PERCENT = 3'd0,
		PH_FLAGS   = 3'd1,
		PH_WIDTH   = 3'd2,
		PH_PREC    = 3'd3,
		PH_DONE    = 3'd4,
		PH_ENDED   = 3'd5
	} phase_t;

	typedef enum logic [3:0] {
		CONV_NONE = 4'd0,
		CONV_D    = 4'd1,
		CONV_I    = 4'd2,
		CONV_U    = 4'd3,
		CONV_X    = 4'd4,
		CONV_XU   = 4'd5,
		CONV_O    = 4'd6,
		CONV_B    = 4'd7,
		CONV_T    = 4'd8,
		CONV_F    = 4'd9,
		CONV_E    = 4'd10,
		CONV_EU   = 4'd11,
		CONV_G    = 4'd12,
		CONV_GU   = 4'd13
	} conv_t;

	typedef struct packed {
		phase_t           phase;
		logic [3:0]       flags;
		logic [NUM_W-1:0] width_acc;
		logic [NUM_W-1:0] prec_acc;
		logic             prec_seen;
		conv_t            conv;
		logic             failed;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_PERCENT, flags: 4'd0, width_acc: '0, prec_acc: '0,
		prec_seen: 1'b0, conv: CONV_NONE, failed: 1'b0
	};

	function automatic conv_t conv_of(input logic [7:0] c);
		conv_t k;
		unique case (c)
			8'h64:   k = CONV_D;
			8'h69:   k = CONV_I;
			8'h75:   k = CONV_U;
			8'h78:   k = CONV_X;
			8'h58:   k = CONV_XU;
			8'h6F:   k = CONV_O;
			8'h62:   k = CONV_B;
			8'h74:   k = CONV_T;
			8'h66:   k = CONV_F;
			8'h65:   k = CONV_E;
			8'h45:   k = CONV_EU;
			8'h67:   k = CONV_G;
			8'h47:   k = CONV_GU;
			default: k = CONV_NONE;
		endcase
		return k;
	endfunction

endpackage

@@ rtl/fsp_if.sv @@
interface fsp_in_if
	import fsp_pkg::*;
	();
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

interface fsp_out_if
	import fsp_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic             valid_res;
	logic             left_align;
	logic             show_plus;
	logic             alt_form;
	logic             zero_pad;
	logic [NUM_W-1:0] field_width;
	logic             has_precision;
	logic [NUM_W-1:0] precision_value;
	logic [3:0]       conversion;

	modport source (
		output valid, output valid_res, output left_align, output show_plus,
		output alt_form, output zero_pad, output field_width, output has_precision,
		output precision_value, output conversion, input ready
	);
	modport sink (
		input valid, input valid_res, input left_align, input show_plus,
		input alt_form, input zero_pad, input field_width, input has_precision,
		input precision_value, input conversion, output ready
	);
endinterface

@@ rtl/format_spec_parser_unit.sv @@
// A result passes through the input stage and then the output register after the item marked last is accepted.
// Throughput: one character item per cycle, save where the stall below holds a last-marked item.
// A pending result waiting on the output register stalls only the next last-marked item.
// Reset (arst_n low) clears the parse state, the input stage and the output valid at once.
`include "format_spec_parser_unit_assert.svh"

module format_spec_parser_unit
	import fsp_pkg::*;
	(
	input  logic       clk,
	input  logic       arst_n,
	fsp_in_if.sink     req,
	fsp_out_if.source  rsp
);

	logic         valid_s1;
	logic [7:0]   ch_s1;
	logic         last_s1;
	parse_state_t st_q;
	parse_state_t st_d;
	logic         out_free;
	logic         advance;
	logic         res_ok;

	logic         is_digit;
	logic [3:0]   digit;
	logic [3:0]   flag_hot;
	logic         is_flag;
	logic [19:0]  width_sum;
	logic [19:0]  prec_sum;
	conv_t        conv_k;

	assign out_free  = !rsp.valid || rsp.ready;
	assign advance   = valid_s1 && (!last_s1 || out_free);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			ch_s1   <= req.ch;
			last_s1 <= req.last;
		end
	end

	assign is_digit  = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
	assign digit     = ch_s1[3:0];
	assign flag_hot  = {ch_s1 == CH_ZERO, ch_s1 == CH_HASH, ch_s1 == CH_PLUS, ch_s1 == CH_MINUS};
	assign is_flag   = |flag_hot;
	assign width_sum = {1'b0, st_q.width_acc, 3'b000} + {3'b000, st_q.width_acc, 1'b0}
		+ {16'd0, digit};
	assign prec_sum  = {1'b0, st_q.prec_acc, 3'b000} + {3'b000, st_q.prec_acc, 1'b0}
		+ {16'd0, digit};
	assign conv_k    = conv_of(ch_s1);

	// Consume the character held in the input stage.
	always_comb begin
		st_d = st_q;
		if (!st_q.failed) begin
			unique case (st_q.phase)
				PH_PERCENT: begin
					if (ch_s1 == CH_PERCENT) st_d.phase = PH_FLAGS;
					else st_d.failed = 1'b1;
				end
				PH_FLAGS: begin
					priority if (is_flag) begin
						if (|(st_q.flags & flag_hot)) st_d.failed = 1'b1;
						else st_d.flags = st_q.flags | flag_hot;
					end else if (is_digit) begin
						st_d.width_acc = {{(NUM_W-4){1'b0}}, digit};
						st_d.phase     = PH_WIDTH;
					end else if (ch_s1 == CH_DOT) begin
						st_d.prec_seen = 1'b1;
						st_d.phase     = PH_PREC;
					end else if (conv_k == CONV_NONE) begin
						st_d.failed = 1'b1;
					end else begin
						st_d.conv  = conv_k;
						st_d.phase = PH_DONE;
					end
				end
				PH_WIDTH: begin
					priority if (is_digit) begin
						if (width_sum > LIMIT_VALUE) st_d.failed = 1'b1;
						else st_d.width_acc = width_sum[NUM_W-1:0];
					end else if (ch_s1 == CH_DOT) begin
						st_d.prec_seen = 1'b1;
						st_d.phase     = PH_PREC;
					end else if (conv_k == CONV_NONE) begin
						st_d.failed = 1'b1;
					end else begin
						st_d.conv  = conv_k;
						st_d.phase = PH_DONE;
					end
				end
				PH_PREC: begin
					priority if (is_digit) begin
						if (prec_sum > LIMIT_VALUE) st_d.failed = 1'b1;
						else st_d.prec_acc = prec_sum[NUM_W-1:0];
					end else if (conv_k == CONV_NONE) begin
						st_d.failed = 1'b1;
					end else begin
						st_d.conv  = conv_k;
						st_d.phase = PH_DONE;
					end
				end
				PH_DONE: begin
					if (ch_s1 == CH_NUL) st_d.phase = PH_ENDED;
					else st_d.failed = 1'b1;
				end
				PH_ENDED: begin
					st_d = st_q;
				end
				default: begin
					st_d.failed = 1'b1;
				end
			endcase
		end
	end

	// The end of the item acts as a terminator: only a finished conversion survives it.
	assign res_ok = !st_d.failed && (st_d.phase == PH_DONE || st_d.phase == PH_ENDED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (advance) begin
			st_q <= last_s1 ? STATE_RESET : st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (advance && last_s1) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			rsp.valid_res       <= res_ok;
			rsp.left_align      <= res_ok && st_d.flags[FBIT_LEFT];
			rsp.show_plus       <= res_ok && st_d.flags[FBIT_SIGN];
			rsp.alt_form        <= res_ok && st_d.flags[FBIT_ALT];
			rsp.zero_pad        <= res_ok && st_d.flags[FBIT_PAD];
			rsp.field_width     <= res_ok ? st_d.width_acc : '0;
			rsp.has_precision   <= res_ok && st_d.prec_seen;
			rsp.precision_value <= res_ok ? st_d.prec_acc : '0;
			rsp.conversion      <= res_ok ? st_d.conv : CONV_NONE;
		end
	end

	`FSP_ASSERT_IMPL(a_invalid_zero, clk, arst_n, rsp.valid && !rsp.valid_res,
		rsp.field_width == '0 && rsp.precision_value == '0 && rsp.conversion == CONV_NONE
		&& !rsp.left_align && !rsp.show_plus && !rsp.alt_form && !rsp.zero_pad
		&& !rsp.has_precision, "invalid result carries nonzero fields")
	`FSP_ASSERT_IMPL(a_valid_conv, clk, arst_n, rsp.valid && rsp.valid_res,
		rsp.conversion != CONV_NONE, "valid result without a conversion letter")
	`FSP_ASSERT_IMPL(a_prec_absent, clk, arst_n, rsp.valid && !rsp.has_precision,
		rsp.precision_value == '0, "precision value without a precision part")
	`FSP_ASSERT_NEXT(a_state_clear, clk, arst_n, advance && last_s1,
		st_q == STATE_RESET && rsp.valid, "state not cleared after the last character")

endmodule

@@ tb/format_spec_parser_unit_tb.sv @@
`timescale 1ns / 1ps

module format_spec_parser_unit_tb;
	import fsp_pkg::*;

	localparam int RANDOM_ITEMS = 1440;

	typedef struct packed {
		logic             valid_res;
		logic             left_align;
		logic             show_plus;
		logic             alt_form;
		logic             zero_pad;
		logic [NUM_W-1:0] field_width;
		logic             has_precision;
		logic [NUM_W-1:0] precision_value;
		conv_t            conversion;
	} spec_result_t;

	typedef struct {
		string        text;
		int           patch_at;
		logic [7:0]   patch_ch;
		bit           typed;
		spec_result_t typed_res;
	} spec_row_t;

	localparam spec_result_t SPEC_REJECTED = '0;
	localparam spec_result_t SPEC_PLAIN_D =
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, CONV_D};
	localparam spec_result_t SPEC_ALL_MAX =
		'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, CONV_GU};

	logic clk;
	logic arst_n;

	fsp_in_if  req ();
	fsp_out_if rsp ();

	format_spec_parser_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Shadow copy of the parse state.
	phase_t      pred_phase;
	logic [3:0]  pred_flags;
	int unsigned pred_width;
	int unsigned pred_prec;
	logic        pred_dot;
	conv_t       pred_conv;
	logic        pred_bad;

	spec_result_t spec_expect[$];
	bit           typed_given[$];
	spec_result_t typed_value[$];
	spec_row_t    spec_rows[$];
	logic [7:0]   spec_chars[$];

	int mismatch_count = 0;
	int burst_left = 0;
	bit quiet_sender = 1'b0;

	logic [7:0]  stall_mask = 8'hFF;
	int unsigned stall_tick = 0;

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic conv_t letter_to_conv(input logic [7:0] c);
		case (c)
			"d":     return CONV_D;
			"i":     return CONV_I;
			"u":     return CONV_U;
			"x":     return CONV_X;
			"X":     return CONV_XU;
			"o":     return CONV_O;
			"b":     return CONV_B;
			"t":     return CONV_T;
			"f":     return CONV_F;
			"e":     return CONV_E;
			"E":     return CONV_EU;
			"g":     return CONV_G;
			"G":     return CONV_GU;
			default: return CONV_NONE;
		endcase
	endfunction

	function automatic void clear_parse();
		pred_phase = PH_PERCENT;
		pred_flags = '0;
		pred_width = 0;
		pred_prec  = 0;
		pred_dot   = 1'b0;
		pred_conv  = CONV_NONE;
		pred_bad   = 1'b0;
	endfunction

	function automatic void take_letter(input logic [7:0] c);
		conv_t k;
		k = letter_to_conv(c);
		if (k == CONV_NONE) begin
			pred_bad = 1'b1;
		end else begin
			pred_conv  = k;
			pred_phase = PH_DONE;
		end
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		int          flag_pos;
		int unsigned acc;
		flag_pos = -1;
		acc = 0;
		if (pred_bad || pred_phase == PH_ENDED)
			return;
		case (pred_phase)
			PH_PERCENT: begin
				if (c == CH_PERCENT)
					pred_phase = PH_FLAGS;
				else
					pred_bad = 1'b1;
			end
			PH_FLAGS: begin
				case (c)
					CH_MINUS: flag_pos = FBIT_LEFT;
					CH_PLUS:  flag_pos = FBIT_SIGN;
					CH_HASH:  flag_pos = FBIT_ALT;
					CH_ZERO:  flag_pos = FBIT_PAD;
					default:  flag_pos = -1;
				endcase
				if (flag_pos >= 0) begin
					if (pred_flags[flag_pos])
						pred_bad = 1'b1;
					else
						pred_flags[flag_pos] = 1'b1;
				end else if (is_digit(c)) begin
					pred_width = c - CH_ZERO;
					pred_phase = PH_WIDTH;
				end else if (c == CH_DOT) begin
					pred_dot   = 1'b1;
					pred_phase = PH_PREC;
				end else begin
					take_letter(c);
				end
			end
			PH_WIDTH: begin
				if (is_digit(c)) begin
					acc = pred_width * 10 + (c - CH_ZERO);
					if (acc > LIMIT_VALUE)
						pred_bad = 1'b1;
					else
						pred_width = acc;
				end else if (c == CH_DOT) begin
					pred_dot   = 1'b1;
					pred_phase = PH_PREC;
				end else begin
					take_letter(c);
				end
			end
			PH_PREC: begin
				if (is_digit(c)) begin
					acc = pred_prec * 10 + (c - CH_ZERO);
					if (acc > LIMIT_VALUE)
						pred_bad = 1'b1;
					else
						pred_prec = acc;
				end else begin
					take_letter(c);
				end
			end
			PH_DONE: begin
				if (c == CH_NUL)
					pred_phase = PH_ENDED;
				else
					pred_bad = 1'b1;
			end
			default: pred_bad = 1'b1;
		endcase
	endfunction

	function automatic spec_result_t close_spec();
		spec_result_t res;
		res = SPEC_REJECTED;
		if (!pred_bad && pred_phase == PH_ENDED) begin
			res.valid_res       = 1'b1;
			res.left_align      = pred_flags[FBIT_LEFT];
			res.show_plus       = pred_flags[FBIT_SIGN];
			res.alt_form        = pred_flags[FBIT_ALT];
			res.zero_pad        = pred_flags[FBIT_PAD];
			res.field_width     = pred_width[NUM_W-1:0];
			res.has_precision   = pred_dot;
			res.precision_value = pred_prec[NUM_W-1:0];
			res.conversion      = pred_conv;
		end
		clear_parse();
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ERROR %s: expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic void check_result();
		spec_result_t want;
		if (spec_expect.size() == 0) begin
			$display("%0t ERROR result with none expected: valid_res %0d conversion %0d",
				$time, rsp.valid_res, rsp.conversion);
			mismatch_count++;
			return;
		end
		want = spec_expect.pop_front();
		check_field("valid_res", want.valid_res, rsp.valid_res);
		check_field("left_align", want.left_align, rsp.left_align);
		check_field("show_plus", want.show_plus, rsp.show_plus);
		check_field("alt_form", want.alt_form, rsp.alt_form);
		check_field("zero_pad", want.zero_pad, rsp.zero_pad);
		check_field("field_width", want.field_width, rsp.field_width);
		check_field("has_precision", want.has_precision, rsp.has_precision);
		check_field("precision_value", want.precision_value, rsp.precision_value);
		check_field("conversion", want.conversion, rsp.conversion);
	endfunction

	always @(posedge clk) begin : monitor
		spec_result_t predicted;
		bit           given;
		spec_result_t typed;
		if (arst_n) begin
			if (rsp.valid && rsp.ready)
				check_result();
			if (req.valid && req.ready) begin
				parse_char(req.ch);
				if (req.last) begin
					// The end of the item acts as a terminating zero byte.
					parse_char(CH_NUL);
					predicted = close_spec();
					given = typed_given.pop_front();
					typed = typed_value.pop_front();
					spec_expect.push_back(given ? typed : predicted);
				end
			end
		end
	end

	// The receiver picks fresh stall patterns at random; some are stall-free.
	always @(posedge clk) begin
		if (stall_tick % 64 == 0) begin
			if ($urandom_range(0, 3) == 0)
				stall_mask = 8'hFF;
			else
				stall_mask = 8'($urandom_range(1, 255));
		end
		rsp.ready <= stall_mask[stall_tick % 8];
		stall_tick++;
	end

	function automatic void add_row(input string text, input bit typed,
			input spec_result_t typed_res, input int patch_at = -1,
			input logic [7:0] patch_ch = CH_NUL);
		spec_row_t row;
		row.text      = text;
		row.typed     = typed;
		row.typed_res = typed_res;
		row.patch_at  = patch_at;
		row.patch_ch  = patch_ch;
		spec_rows.push_back(row);
	endfunction

	task automatic push_char(input logic [7:0] c, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = quiet_sender ? 0 : $urandom_range(0, 5);
			burst_left = $urandom_range(1, 16);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.ch    <= c;
		req.last  <= is_last;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic send_spec(input bit typed, input spec_result_t typed_res);
		typed_given.push_back(typed);
		typed_value.push_back(typed_res);
		if ($urandom_range(0, 30) == 0)
			quiet_sender = !quiet_sender;
		foreach (spec_chars[i])
			push_char(spec_chars[i], i == spec_chars.size() - 1);
	endtask

	function automatic void append_number(input int unsigned value);
		string digits;
		digits = $sformatf("%0d", value);
		for (int i = 0; i < digits.len(); i++)
			spec_chars.push_back(digits[i]);
	endfunction

	function automatic int unsigned pick_number();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(1, 9);
			1:       return $urandom_range(10, 999);
			2:       return $urandom_range(1000, 65535);
			default: return $urandom_range(65530, 65545);
		endcase
	endfunction

	function automatic void make_random_spec();
		logic [7:0] flag_set [4];
		logic [7:0] swap_ch;
		string      letters;
		int         n;
		int         pick;
		int         shape;
		letters = "diuxXobtfeEgG";
		spec_chars.delete();
		shape = $urandom_range(0, 99);
		if (shape >= 88) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				spec_chars.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				spec_chars[0] = CH_PERCENT;
			return;
		end
		spec_chars.push_back(CH_PERCENT);
		flag_set = '{CH_MINUS, CH_PLUS, CH_HASH, CH_ZERO};
		for (int i = 3; i > 0; i--) begin
			pick = $urandom_range(0, i);
			swap_ch = flag_set[i];
			flag_set[i] = flag_set[pick];
			flag_set[pick] = swap_ch;
		end
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++)
			spec_chars.push_back(flag_set[i]);
		if (n > 0 && $urandom_range(0, 19) == 0)
			spec_chars.push_back(flag_set[$urandom_range(0, n - 1)]);
		if ($urandom_range(0, 1))
			append_number(pick_number());
		if ($urandom_range(0, 4) < 2) begin
			spec_chars.push_back(CH_DOT);
			if ($urandom_range(0, 3) != 0) begin
				// Leading zeros are legal in a precision.
				if ($urandom_range(0, 5) == 0)
					spec_chars.push_back(CH_ZERO);
				append_number(pick_number());
			end
		end
		spec_chars.push_back(letters[$urandom_range(0, letters.len() - 1)]);
		case ($urandom_range(0, 19))
			0, 1: begin
				spec_chars.push_back(CH_NUL);
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++)
					spec_chars.push_back(8'($urandom_range(0, 255)));
			end
			2: spec_chars.push_back(8'($urandom_range(1, 255)));
			default: ;
		endcase
		// Some well-formed specifiers get cut short or have one character replaced.
		if (shape >= 75) begin
			if ($urandom_range(0, 1) && spec_chars.size() > 1)
				void'(spec_chars.pop_back());
			else
				spec_chars[$urandom_range(0, spec_chars.size() - 1)] =
					8'($urandom_range(0, 255));
		end
	endfunction

	initial begin : stimulus
		int sent;
		arst_n    = 1'b0;
		req.valid = 1'b0;
		req.ch    = '0;
		req.last  = 1'b0;
		clear_parse();

		add_row("%d", 1'b1, SPEC_PLAIN_D);
		add_row("%-+#065535.65535G", 1'b1, SPEC_ALL_MAX);
		add_row("%65536d", 1'b1, SPEC_REJECTED);
		add_row("%.65536f", 1'b1, SPEC_REJECTED);
		add_row("%--d", 1'b1, SPEC_REJECTED);
		add_row("%007d", 1'b1, SPEC_REJECTED);
		add_row("d", 1'b1, SPEC_REJECTED);
		add_row("%", 1'b1, SPEC_REJECTED);
		add_row("%dx", 1'b1, SPEC_REJECTED);
		add_row("%q", 1'b1, SPEC_REJECTED);
		add_row("%%", 1'b1, SPEC_REJECTED);
		add_row("?", 1'b1, SPEC_REJECTED, 0, CH_NUL);
		add_row("%?d", 1'b1, SPEC_REJECTED, 1, CH_NUL);
		add_row("%?d", 1'b1, SPEC_REJECTED, 1, 8'hFF);
		add_row("%d?zz", 1'b1, SPEC_PLAIN_D, 2, CH_NUL);
		add_row("%1.", 1'b1, SPEC_REJECTED);
		add_row("%+10.3i", 1'b0, SPEC_REJECTED);
		add_row("%#x", 1'b0, SPEC_REJECTED);
		add_row("%-X", 1'b0, SPEC_REJECTED);
		add_row("%05o", 1'b0, SPEC_REJECTED);
		add_row("%.b", 1'b0, SPEC_REJECTED);
		add_row("%12t", 1'b0, SPEC_REJECTED);
		add_row("%1u", 1'b0, SPEC_REJECTED);
		add_row("%#e", 1'b0, SPEC_REJECTED);
		add_row("%+E", 1'b0, SPEC_REJECTED);
		add_row("%9.99g", 1'b0, SPEC_REJECTED);
		add_row("%0.0f", 1'b0, SPEC_REJECTED);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (spec_rows[r]) begin
			spec_chars.delete();
			for (int j = 0; j < spec_rows[r].text.len(); j++)
				spec_chars.push_back(spec_rows[r].text[j]);
			if (spec_rows[r].patch_at >= 0)
				spec_chars[spec_rows[r].patch_at] = spec_rows[r].patch_ch;
			send_spec(spec_rows[r].typed, spec_rows[r].typed_res);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			make_random_spec();
			sent += spec_chars.size();
			send_spec(1'b0, SPEC_REJECTED);
		end
		req.valid <= 1'b0;
		// Let the monitor record the final accepted item before draining.
		@(posedge clk);

		while (spec_expect.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("%0t ERROR timeout with %0d results outstanding", $time, spec_expect.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
